[design/bdlp_pkg.sv]
`default_nettype none
package bdlp_pkg;

    localparam int BDLP_TIME_WIDTH = 32;

    localparam int NOW_WIDTH = 32;
    localparam int CFG_WIDTH = 16;
    localparam int CFG_ADDR_WIDTH = 1;

    localparam int S_TDATA_WIDTH = 40;
    localparam int M_TDATA_WIDTH = 8;

    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LONG_PRESS = 1'b1;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd800;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_BEGIN = 2'd1,
        OP_PRIME_LOW = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_PRESSED = 2'd1,
        EV_SHORT_RELEASED = 2'd2,
        EV_LONG_PRESSED = 2'd3
    } event_t;

    typedef struct packed {
        logic raw_level;
        logic [NOW_WIDTH-1:0] now_ms;
        op_t op;
    } in_item_t;

    typedef struct packed {
        logic pending_debounce;
        event_t event_res;
    } res_item_t;

endpackage
`default_nettype wire

[design/bdlp_in_reg.sv]
`default_nettype none
module bdlp_in_reg
    import bdlp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire in_item_t s_item,
    input  wire logic     advance,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule
`default_nettype wire

[design/bdlp_core.sv]
`default_nettype none
module bdlp_core
    import bdlp_pkg::*;
#(
    parameter int TIME_WIDTH = BDLP_TIME_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_WIDTH-1:0]      cfg_wdata,
    input  wire in_item_t                  item,
    input  wire logic                      advance,
    output res_item_t                      result
);

    logic [CFG_WIDTH-1:0]  debounce_reg;
    logic [CFG_WIDTH-1:0]  long_press_reg;

    logic                  stable_reg;
    logic                  stable_next;
    logic                  last_raw_reg;
    logic                  last_raw_next;
    logic                  long_rep_reg;
    logic                  long_rep_next;
    logic [TIME_WIDTH-1:0] change_time_reg;
    logic [TIME_WIDTH-1:0] change_time_next;
    logic [TIME_WIDTH-1:0] press_time_reg;
    logic [TIME_WIDTH-1:0] press_time_next;

    logic [TIME_WIDTH+NOW_WIDTH-1:0] now_ext;
    logic [TIME_WIDTH+CFG_WIDTH-1:0] debounce_ext;
    logic [TIME_WIDTH+CFG_WIDTH-1:0] long_press_ext;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] since_change;
    logic [TIME_WIDTH-1:0] since_press;
    logic                  settled;
    event_t                ev;

    assign now_ext = {{TIME_WIDTH{1'b0}}, item.now_ms};
    assign debounce_ext = {{TIME_WIDTH{1'b0}}, debounce_reg};
    assign long_press_ext = {{TIME_WIDTH{1'b0}}, long_press_reg};
    assign now_t = now_ext[TIME_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DEBOUNCE: debounce_reg <= cfg_wdata;
                CFG_LONG_PRESS: long_press_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        stable_next = stable_reg;
        last_raw_next = last_raw_reg;
        long_rep_next = long_rep_reg;
        change_time_next = change_time_reg;
        press_time_next = press_time_reg;
        ev = EV_NONE;
        settled = 1'b0;
        since_change = '0;
        since_press = '0;
        case (item.op)
            OP_SAMPLE: begin
                if (item.raw_level != last_raw_reg) begin
                    last_raw_next = item.raw_level;
                    change_time_next = now_t;
                end
                since_change = now_t - change_time_next;
                settled = (since_change >= debounce_ext[TIME_WIDTH-1:0])
                    && (stable_reg != item.raw_level);
                since_press = now_t - press_time_reg;
                if (settled) begin
                    stable_next = item.raw_level;
                    long_rep_next = 1'b0;
                    if (!item.raw_level) begin
                        press_time_next = now_t;
                        ev = EV_PRESSED;
                    end else begin
                        press_time_next = '0;
                        if (!long_rep_reg) begin
                            ev = EV_SHORT_RELEASED;
                        end
                    end
                end else if (!stable_reg && !long_rep_reg
                             && since_press >= long_press_ext[TIME_WIDTH-1:0]) begin
                    long_rep_next = 1'b1;
                    ev = EV_LONG_PRESSED;
                end
            end
            OP_BEGIN: begin
                stable_next = item.raw_level;
                last_raw_next = item.raw_level;
                change_time_next = now_t;
                press_time_next = item.raw_level ? '0 : now_t;
                long_rep_next = 1'b0;
            end
            OP_PRIME_LOW: begin
                stable_next = 1'b0;
                last_raw_next = 1'b0;
                change_time_next = now_t;
                press_time_next = now_t;
                long_rep_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg <= 1'b1;
            last_raw_reg <= 1'b1;
            long_rep_reg <= 1'b0;
            change_time_reg <= '0;
            press_time_reg <= '0;
        end else if (advance) begin
            stable_reg <= stable_next;
            last_raw_reg <= last_raw_next;
            long_rep_reg <= long_rep_next;
            change_time_reg <= change_time_next;
            press_time_reg <= press_time_next;
        end
    end

    assign result.event_res = ev;
    assign result.pending_debounce = stable_next != last_raw_next;

endmodule
`default_nettype wire

[design/bdlp_out_reg.sv]
`default_nettype none
module bdlp_out_reg
    import bdlp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_valid,
    input  wire res_item_t result,
    output logic           advance,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output res_item_t      m_item
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;

    assign advance = item_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_item = item_reg;

endmodule
`default_nettype wire

[design/button_debounce_long_press_unit.sv]
// Debouncer for an active-low push button with long-press detection.
// Each input word carries an operation, a millisecond timestamp and the raw
// pin level; each accepted word yields exactly one result word with the
// event code and the pending-debounce flag, in input order.
// The debounce and long-press times are written through the plain write
// port (index 0 and 1); the user must write them only while no word is in
// flight, as the block does not enforce it. A word accepted into the input
// register is evaluated against the button state and placed in the output
// register, from which its result is taken. The state update is a single
// combinational step of subtracts and compares, so one word is accepted and
// one result is delivered in every cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its word and the
// input register keeps taking one more word; after that s_tready falls
// until the stall clears. Nothing is dropped.
// Synchronous reset empties both registers, restores the default times
// (30 ms and 800 ms) and sets the button to released with no long press.
`default_nettype none
module button_debounce_long_press_unit
    import bdlp_pkg::*;
#(
    parameter int TIME_WIDTH = BDLP_TIME_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_WIDTH-1:0]      cfg_wdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: op[1:0], now_ms[33:2], raw_level[34], zero pad.
    input  wire logic [S_TDATA_WIDTH-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // Fields from bit 0: event_res[1:0], pending_debounce[2], zero pad.
    output logic [M_TDATA_WIDTH-1:0]       m_tdata
);

    localparam int ItemBits = $bits(in_item_t);
    localparam int ResBits = $bits(res_item_t);

    in_item_t  s_item;
    in_item_t  item;
    logic      item_valid;
    logic      advance;
    res_item_t result;
    res_item_t m_item;

    assign s_item = in_item_t'(s_tdata[ItemBits-1:0]);

    bdlp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bdlp_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .advance   (advance),
        .result    (result)
    );

    bdlp_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_item     (m_item)
    );

    assign m_tdata = {{(M_TDATA_WIDTH-ResBits){1'b0}}, m_item};

endmodule
`default_nettype wire

[design/bdlp_checker.sv]
`default_nettype none
module bdlp_checker
    import bdlp_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [M_TDATA_WIDTH-1:0] m_tdata
);

    // After reset both registers are empty.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // A stalled result word is held unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // The pad bits of a result word stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_WIDTH-1:3] == '0)
        else $error("result pad bits not zero");

    // A word taken while the output is free shows up as a result once it has passed the input and output registers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("accepted word produced no result");

    // The input side is never blocked while the output side is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!m_tvalid) |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[test/debounce_event_checker.sv]
`default_nettype none
module debounce_event_checker
    import bdlp_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_WIDTH-1:0]      cfg_wdata,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0]  s_tdata,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [M_TDATA_WIDTH-1:0]  m_tdata,
    output int                             mismatch_count,
    output int                             results_owed
);

    logic [CFG_WIDTH-1:0] debounce_time;
    logic [CFG_WIDTH-1:0] long_press_time;
    logic                 stable_lvl;
    logic                 last_raw;
    logic                 long_done;
    logic [NOW_WIDTH-1:0] raw_change_at;
    logic [NOW_WIDTH-1:0] press_start_at;

    res_item_t expected_events[$];
    int        errors = 0;

    task automatic predict_event(input in_item_t w, output res_item_t r);
        logic [NOW_WIDTH-1:0] since;
        event_t               ev;
        bit                   changed;
        ev = EV_NONE;
        changed = 1'b0;
        case (w.op)
            OP_SAMPLE: begin
                if (w.raw_level != last_raw) begin
                    last_raw = w.raw_level;
                    raw_change_at = w.now_ms;
                end
                since = w.now_ms - raw_change_at;
                if (since >= {16'd0, debounce_time} && stable_lvl != w.raw_level) begin
                    stable_lvl = w.raw_level;
                    changed = 1'b1;
                    if (!stable_lvl) begin
                        press_start_at = w.now_ms;
                        ev = EV_PRESSED;
                    end else begin
                        if (!long_done) begin
                            ev = EV_SHORT_RELEASED;
                        end
                        press_start_at = '0;
                    end
                    long_done = 1'b0;
                end
                since = w.now_ms - press_start_at;
                if (!changed && !stable_lvl && !long_done &&
                    since >= {16'd0, long_press_time}) begin
                    long_done = 1'b1;
                    ev = EV_LONG_PRESSED;
                end
            end
            OP_BEGIN: begin
                stable_lvl = w.raw_level;
                last_raw = w.raw_level;
                raw_change_at = w.now_ms;
                press_start_at = w.raw_level ? '0 : w.now_ms;
                long_done = 1'b0;
            end
            OP_PRIME_LOW: begin
                stable_lvl = 1'b0;
                last_raw = 1'b0;
                raw_change_at = w.now_ms;
                press_start_at = w.now_ms;
                long_done = 1'b0;
            end
            default: begin
            end
        endcase
        r.event_res = ev;
        r.pending_debounce = stable_lvl != last_raw;
    endtask

    always @(posedge aclk) begin
        in_item_t  word_in;
        res_item_t want;
        res_item_t got;
        if (!aresetn) begin
            debounce_time = DEBOUNCE_RESET;
            long_press_time = LONG_PRESS_RESET;
            stable_lvl = 1'b1;
            last_raw = 1'b1;
            long_done = 1'b0;
            raw_change_at = '0;
            press_start_at = '0;
            expected_events.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_DEBOUNCE) begin
                    debounce_time = cfg_wdata;
                end else if (cfg_addr == CFG_LONG_PRESS) begin
                    long_press_time = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                word_in = s_tdata[$bits(in_item_t)-1:0];
                predict_event(word_in, want);
                expected_events.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(res_item_t)-1:0];
                if (expected_events.size() == 0) begin
                    $display("%0t: result word with none expected, actual event %0d pending %0d",
                             $time, got.event_res, got.pending_debounce);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $display("%0t: event_res mismatch, expected %0d, actual %0d",
                                 $time, want.event_res, got.event_res);
                        errors++;
                    end
                    if (got.pending_debounce !== want.pending_debounce) begin
                        $display("%0t: pending_debounce mismatch, expected %0d, actual %0d",
                                 $time, want.pending_debounce, got.pending_debounce);
                        errors++;
                    end
                end
            end
        end
        results_owed <= expected_events.size();
        mismatch_count <= errors;
    end

endmodule
`default_nettype wire

[test/tb_button_debounce_long_press_unit.sv]
`default_nettype none
module tb_button_debounce_long_press_unit;
    import bdlp_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  HOLD_OFF_CYCLES = 400;
    localparam int  PHASE_WORDS = 120;
    localparam op_t OP_UNUSED = op_t'(2'd3);

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
    logic [CFG_WIDTH-1:0]      cfg_wdata = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_WIDTH-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0]  m_tdata;

    int                   fail_total;
    int                   results_owed;
    int                   cycle_count = 0;
    logic                 hold_off_req = 1'b0;
    logic [NOW_WIDTH-1:0] clock_ms = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    button_debounce_long_press_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    debounce_event_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (fail_total),
        .results_owed   (results_owed)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [NOW_WIDTH-1:0] pick_step(input logic [CFG_WIDTH-1:0] deb,
                                                       input logic [CFG_WIDTH-1:0] lp);
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return $urandom_range(0, deb / 2);
            3: return NOW_WIDTH'(deb);
            4: return (deb == 0) ? '0 : NOW_WIDTH'(deb) - 1;
            5: return NOW_WIDTH'(deb) + 1;
            6, 7: return $urandom_range(0, lp / 4 + 1);
            8: return NOW_WIDTH'(lp);
            default: return $urandom_range(0, 2 * lp + deb + 2);
        endcase
    endfunction

    function automatic in_item_t make_word(input op_t op, input logic [NOW_WIDTH-1:0] now,
                                           input logic raw);
        in_item_t w;
        w.op = op;
        w.now_ms = now;
        w.raw_level = raw;
        return w;
    endfunction

    // The receiver drops ready in short random gaps, and once holds it low for a
    // long stretch so that the block fills up and stalls its input.
    initial begin
        int  gap;
        bit  held;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_idle();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    task automatic send_word(input in_item_t w);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_WIDTH'(w);
        do @(posedge aclk); while (!s_tready);
        gap = pick_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_WIDTH-1:0] deb, input logic [CFG_WIDTH-1:0] lp);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge aclk);
        cfg_addr <= CFG_LONG_PRESS;
        cfg_wdata <= lp;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly a button that is pressed and released with some bounce, mixed with
    // re-initializations, unused operations and words at random times.
    task automatic run_phase(input logic [CFG_WIDTH-1:0] deb, input logic [CFG_WIDTH-1:0] lp,
                             input bit drain_midway);
        int       n;
        int       r;
        int       hold_left;
        logic     level;
        logic     raw;
        in_item_t w;
        configure(deb, lp);
        level = 1'b1;
        hold_left = $urandom_range(1, 6);
        for (n = 0; n < PHASE_WORDS; n++) begin
            if (drain_midway && n == PHASE_WORDS / 2) begin
                drain();
            end
            r = $urandom_range(0, 99);
            if (r < 78) begin
                if (hold_left == 0) begin
                    level = ~level;
                    hold_left = $urandom_range(1, 10);
                end
                hold_left--;
                raw = ($urandom_range(0, 99) < 15) ? ~level : level;
                clock_ms += pick_step(deb, lp);
                w = make_word(OP_SAMPLE, clock_ms, raw);
            end else if (r < 84) begin
                w = make_word(OP_BEGIN, clock_ms, 1'($urandom_range(0, 1)));
            end else if (r < 88) begin
                w = make_word(OP_PRIME_LOW, clock_ms, 1'($urandom_range(0, 1)));
            end else if (r < 91) begin
                w = make_word(OP_UNUSED, $urandom(), 1'($urandom_range(0, 1)));
            end else begin
                clock_ms = $urandom();
                w = make_word(op_t'($urandom_range(0, 3)), clock_ms,
                              1'($urandom_range(0, 1)));
            end
            send_word(w);
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(make_word(OP_BEGIN, 32'd1000, 1'b1));
        send_word(make_word(OP_SAMPLE, 32'd1000, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd1029, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd1030, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd1829, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd1830, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd1900, 1'b1));
        send_word(make_word(OP_SAMPLE, 32'd1910, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd1920, 1'b1));
        send_word(make_word(OP_SAMPLE, 32'd1950, 1'b1));
        send_word(make_word(OP_SAMPLE, 32'd2000, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd2030, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd2100, 1'b1));
        send_word(make_word(OP_SAMPLE, 32'd2130, 1'b1));
        send_word(make_word(OP_PRIME_LOW, 32'd3000, 1'b1));
        send_word(make_word(OP_SAMPLE, 32'd3000, 1'b0));
        send_word(make_word(OP_UNUSED, 32'd3500, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'd3800, 1'b1));
        send_word(make_word(OP_BEGIN, 32'hFFFF_FFF0, 1'b1));
        send_word(make_word(OP_SAMPLE, 32'hFFFF_FFF8, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'h0000_0016, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'h0000_0336, 1'b0));
        send_word(make_word(OP_BEGIN, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'h0000_031F, 1'b0));
        send_word(make_word(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1));
        drain();

        clock_ms = 32'd5000;
        run_phase(16'd0, 16'd0, 1'b0);
        hold_off_req <= 1'b1;
        run_phase(16'd5, 16'd40, 1'b1);
        run_phase(16'd65535, 16'd65535, 1'b0);
        run_phase(16'd0, 16'd1, 1'b0);
        run_phase(16'd65535, 16'd0, 1'b0);
        run_phase(DEBOUNCE_RESET, LONG_PRESS_RESET, 1'b0);

        if (fail_total == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
design/bdlp_pkg.sv
design/bdlp_in_reg.sv
design/bdlp_core.sv
design/bdlp_out_reg.sv
design/button_debounce_long_press_unit.sv
design/bdlp_checker.sv
test/debounce_event_checker.sv
test/tb_button_debounce_long_press_unit.sv
